/* src/sccb_pkg.sv */
// Package with the sequencer step codes, command codes and field widths of the SCCB master.
package sccb_pkg;

   localparam int unsigned STEP_W = 5;

   localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
   localparam logic [STEP_W-1:0] S_ST_A     = 5'd1;
   localparam logic [STEP_W-1:0] S_ST_B     = 5'd2;
   localparam logic [STEP_W-1:0] S_TX_LO    = 5'd3;
   localparam logic [STEP_W-1:0] S_TX_HI    = 5'd4;
   localparam logic [STEP_W-1:0] S_ACK_LO   = 5'd5;
   localparam logic [STEP_W-1:0] S_ACK_HI   = 5'd6;
   localparam logic [STEP_W-1:0] S_ACK_END  = 5'd7;
   localparam logic [STEP_W-1:0] S_GAP      = 5'd8;
   localparam logic [STEP_W-1:0] S_STOP_LO  = 5'd9;
   localparam logic [STEP_W-1:0] S_STOP_HI  = 5'd10;
   localparam logic [STEP_W-1:0] S_STOP_END = 5'd11;
   localparam logic [STEP_W-1:0] S_GAP_S1   = 5'd12;
   localparam logic [STEP_W-1:0] S_GAP_S2   = 5'd13;
   localparam logic [STEP_W-1:0] S_RX_REL   = 5'd14;
   localparam logic [STEP_W-1:0] S_RX_HI    = 5'd15;
   localparam logic [STEP_W-1:0] S_RX_LO    = 5'd16;
   localparam logic [STEP_W-1:0] S_NA_HI    = 5'd17;
   localparam logic [STEP_W-1:0] S_NA_LO    = 5'd18;
   localparam logic [STEP_W-1:0] S_NA_SDA   = 5'd19;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_TICKS_PER_UNIT = 1'b1;

   localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'h42;
   localparam logic [15:0] TICKS_PER_UNIT_RESET = 16'd1;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned CSR_DATA_W = 16;

   // Byte numbers within one transaction.
   localparam logic [1:0] BYTE_ADDR = 2'd0;
   localparam logic [1:0] BYTE_REG  = 2'd1;
   localparam logic [1:0] BYTE_DATA = 2'd2;

endpackage

/* src/sccb_register_master.sv */
// SCCB register master: tick sequencer for three-phase writes and split two-phase reads.
//
//  channel | direction | beat contents
//  req_    | in        | one tick: cmd, reg_addr, write_value, sda_sample
//  rsp_    | out       | line levels, busy, done, read byte, ack error after that tick
//  csr_    | in        | register write: 0 device_address, 1 ticks_per_unit
//
// Each accepted beat advances the sequencer registers; one response beat leaves per cycle unless rsp_ stalls.
// The sequencer state lives in registers updated on accept, the response sits in an
// output register backed by a one-beat skid register, so a stalled rsp_ side only
// holds off req_ once both are full.
// Reset returns the sequencer to idle with SCL and SDA driven high.
// csr_ready is always high; registers should be written only while idle.
module sccb_register_master (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] cmd, [9:2] reg_addr, [17:10] write_value, [18] sda_sample, [23:19] zero
   input  logic [sccb_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] scl_out, [1] sda_drive, [2] sda_enable, [3] busy_res, [4] done_res,
   // [12:5] read_result, [13] ack_error, [15:14] zero
   output logic [sccb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [sccb_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sccb_pkg::*;

   logic [7:0]        dev_addr_ff;
   logic [15:0]       tpu_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [2:0]        bit_idx_ff, bit_idx_in;
   logic [7:0]        shift_ff, shift_in;
   logic [15:0]       unit_cnt_ff, unit_cnt_in;
   logic              is_read_ff, is_read_in;
   logic [7:0]        held_reg_ff, held_reg_in;
   logic [7:0]        held_val_ff, held_val_in;
   logic [7:0]        rx_byte_ff, rx_byte_in;
   logic              err_ff, err_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic              en_ff, en_in;
   logic [1:0]        byte_num_ff, byte_num_in;

   logic                  rsp_valid_ff, skid_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, skid_data_ff, beat_data;

   logic        accept, out_free, done, go;
   logic [1:0]  cmd;
   logic        sda_s;
   logic [15:0] limit;
   logic [16:0] cnt_next;
   logic [STEP_W-1:0] tgt;

   assign cmd        = req_tdata[1:0];
   assign sda_s      = req_tdata[18];
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign limit      = (tpu_ff == 16'd0) ? 16'd1 : tpu_ff;
   assign cnt_next   = {1'b0, unit_cnt_ff} + 17'd1;

   always_comb begin
      step_in     = step_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      unit_cnt_in = unit_cnt_ff;
      is_read_in  = is_read_ff;
      held_reg_in = held_reg_ff;
      held_val_in = held_val_ff;
      rx_byte_in  = rx_byte_ff;
      err_in      = err_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      en_in       = en_ff;
      byte_num_in = byte_num_ff;
      done        = 1'b0;
      go          = 1'b0;
      tgt         = S_IDLE;

      // First pick the next step and the bookkeeping that precedes its line event.
      if (accept) begin
         if (step_ff == S_IDLE) begin
            if (cmd == CMD_READ || cmd == CMD_WRITE) begin
               is_read_in  = (cmd == CMD_READ);
               held_reg_in = req_tdata[9:2];
               held_val_in = req_tdata[17:10];
               if (cmd == CMD_WRITE) begin
                  err_in = 1'b0;
               end
               byte_num_in = BYTE_ADDR;
               bit_idx_in  = 3'd0;
               shift_in    = dev_addr_ff;
               unit_cnt_in = 16'd0;
               go          = 1'b1;
               tgt         = S_ST_A;
            end
         end else if (cnt_next >= {1'b0, limit}) begin
            unit_cnt_in = 16'd0;
            go          = 1'b1;
            unique case (step_ff)
               S_ST_A: tgt = S_ST_B;
               S_ST_B: begin
                  bit_idx_in = 3'd0;
                  tgt        = S_TX_LO;
               end
               S_TX_LO: tgt = S_TX_HI;
               S_TX_HI: begin
                  if (bit_idx_ff != 3'd7) begin
                     bit_idx_in = bit_idx_ff + 3'd1;
                     shift_in   = {shift_ff[6:0], 1'b0};
                     tgt        = S_TX_LO;
                  end else begin
                     tgt = S_ACK_LO;
                  end
               end
               S_ACK_LO: tgt = S_ACK_HI;
               S_ACK_HI: tgt = S_ACK_END;
               S_ACK_END: begin
                  if (!is_read_ff && byte_num_ff == BYTE_DATA) tgt = S_STOP_HI;
                  else tgt = S_GAP;
               end
               S_GAP: begin
                  if (is_read_ff && byte_num_ff == BYTE_REG) begin
                     tgt = S_STOP_LO;
                  end else if (is_read_ff && byte_num_ff == BYTE_DATA) begin
                     tgt = S_RX_REL;
                  end else begin
                     byte_num_in = byte_num_ff + 2'd1;
                     shift_in    = (byte_num_ff == BYTE_ADDR) ? held_reg_ff : held_val_ff;
                     bit_idx_in  = 3'd0;
                     tgt         = S_TX_LO;
                  end
               end
               S_STOP_LO: tgt = S_STOP_HI;
               S_STOP_HI: tgt = S_STOP_END;
               S_STOP_END: begin
                  if (is_read_ff && byte_num_ff == BYTE_REG) begin
                     tgt = S_GAP_S1;
                  end else begin
                     go      = 1'b0;
                     step_in = S_IDLE;
                     done    = 1'b1;
                  end
               end
               S_GAP_S1: tgt = S_GAP_S2;
               S_GAP_S2: begin
                  byte_num_in = BYTE_DATA;
                  shift_in    = dev_addr_ff | 8'h01;
                  tgt         = S_ST_A;
               end
               S_RX_REL: begin
                  bit_idx_in = 3'd0;
                  tgt        = S_RX_HI;
               end
               S_RX_HI: tgt = S_RX_LO;
               S_RX_LO: begin
                  if (bit_idx_ff != 3'd7) begin
                     bit_idx_in = bit_idx_ff + 3'd1;
                     tgt        = S_RX_HI;
                  end else begin
                     tgt = S_NA_HI;
                  end
               end
               S_NA_HI:  tgt = S_NA_LO;
               S_NA_LO:  tgt = S_NA_SDA;
               S_NA_SDA: tgt = S_STOP_LO;
               default: begin
                  go      = 1'b0;
                  step_in = S_IDLE;
               end
            endcase
         end else begin
            unit_cnt_in = cnt_next[15:0];
         end
      end

      // Then apply the line event of the step being entered.
      if (go) begin
         step_in = tgt;
         unique case (tgt)
            S_ST_A: begin
               scl_in = 1'b1;
               sda_in = 1'b1;
               en_in  = 1'b1;
            end
            S_ST_B: sda_in = 1'b0;
            S_TX_LO: begin
               scl_in = 1'b0;
               sda_in = shift_in[7];
               en_in  = 1'b1;
            end
            S_TX_HI: scl_in = 1'b1;
            S_ACK_LO: begin
               scl_in = 1'b0;
               en_in  = 1'b0;
            end
            S_ACK_HI: scl_in = 1'b1;
            S_ACK_END: begin
               if (!is_read_in && sda_s) err_in = 1'b1;
               scl_in = 1'b0;
               en_in  = 1'b1;
               if (!is_read_in && byte_num_in == BYTE_DATA) sda_in = 1'b0;
            end
            S_STOP_LO:  sda_in = 1'b0;
            S_STOP_HI:  scl_in = 1'b1;
            S_STOP_END: sda_in = 1'b1;
            S_RX_REL:   en_in = 1'b0;
            S_RX_HI: begin
               scl_in   = 1'b1;
               shift_in = {shift_in[6:0], sda_s};
            end
            S_RX_LO: begin
               scl_in = 1'b0;
               if (bit_idx_in == 3'd7) begin
                  en_in      = 1'b1;
                  rx_byte_in = shift_in;
               end
            end
            S_NA_HI: begin
               sda_in = 1'b1;
               scl_in = 1'b1;
            end
            S_NA_LO:  scl_in = 1'b0;
            S_NA_SDA: sda_in = 1'b0;
            default: ;
         endcase
      end

      beat_data = {2'b00, err_in, rx_byte_in, done, (step_in != S_IDLE), en_in, sda_in, scl_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff   <= DEVICE_ADDRESS_RESET;
         tpu_ff        <= TICKS_PER_UNIT_RESET;
         step_ff       <= S_IDLE;
         bit_idx_ff    <= 3'd0;
         shift_ff      <= 8'd0;
         unit_cnt_ff   <= 16'd0;
         is_read_ff    <= 1'b0;
         held_reg_ff   <= 8'd0;
         held_val_ff   <= 8'd0;
         rx_byte_ff    <= 8'd0;
         err_ff        <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         en_ff         <= 1'b1;
         byte_num_ff   <= BYTE_ADDR;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DEVICE_ADDRESS: dev_addr_ff <= csr_data[7:0];
               CSR_TICKS_PER_UNIT: tpu_ff      <= csr_data;
            endcase
         end
         step_ff     <= step_in;
         bit_idx_ff  <= bit_idx_in;
         shift_ff    <= shift_in;
         unit_cnt_ff <= unit_cnt_in;
         is_read_ff  <= is_read_in;
         held_reg_ff <= held_reg_in;
         held_val_ff <= held_val_in;
         rx_byte_ff  <= rx_byte_in;
         err_ff      <= err_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
         en_ff       <= en_in;
         byte_num_ff <= byte_num_in;

         // The skid register only fills when a beat arrives while the output is stalled.
         if (out_free) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) rsp_data_ff <= skid_data_ff;
         else rsp_data_ff <= beat_data;
      end else if (accept) begin
         skid_data_ff <= beat_data;
      end
   end

   // The skid register never holds a beat while the output register is empty.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // A finishing beat reports the sequencer as no longer busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[4]) |-> !rsp_tdata[3])
      else $error("done beat still reports busy");

   // SDA is released only in the middle of a transaction.
   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[2]) |-> rsp_tdata[3])
      else $error("SDA released while idle");

   // An idle sequencer keeps both lines driven high.
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      (step_ff == S_IDLE) |-> (scl_ff && sda_ff && en_ff))
      else $error("lines not parked high while idle");

endmodule

/* tb/sv/sccb_line_checker.sv */
// Checker for the SCCB register master: predicts the line levels of every tick and compares them.
module sccb_line_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [sccb_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [sccb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [sccb_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              fail_count,
   output int                              pending_beats,
   output logic                            seq_active
);
   import sccb_pkg::*;

   typedef struct {
      logic       scl;
      logic       sda_lvl;
      logic       sda_en;
      logic       busy;
      logic       done;
      logic [7:0] rx_byte;
      logic       err;
   } line_state_type;

   localparam int PRINT_CAP = 200;

   line_state_type levels_due[$];
   int             mismatches = 0;

   // Configuration copy.
   logic [7:0]  dev_addr;
   logic [15:0] unit_ticks;

   // Sequencer copy.
   logic [STEP_W-1:0] step;
   logic [3:0]        bit_idx;
   logic [7:0]        shreg;
   int                unit_cnt;
   logic              rd_mode;
   logic [7:0]        held_reg;
   logic [7:0]        held_val;
   logic [7:0]        rx_byte;
   logic              err_flag;
   logic              scl, sda_lvl, sda_en;
   logic [1:0]        byte_no;

   initial begin
      fail_count    = 0;
      pending_beats = 0;
      seq_active    = 1'b0;
   end

   function automatic void clear_sequencer();
      dev_addr   = DEVICE_ADDRESS_RESET;
      unit_ticks = TICKS_PER_UNIT_RESET;
      step       = S_IDLE;
      bit_idx    = '0;
      shreg      = '0;
      unit_cnt   = 0;
      rd_mode    = 1'b0;
      held_reg   = '0;
      held_val   = '0;
      rx_byte    = '0;
      err_flag   = 1'b0;
      scl        = 1'b1;
      sda_lvl    = 1'b1;
      sda_en     = 1'b1;
      byte_no    = BYTE_ADDR;
   endfunction

   // Line levels change on the tick an event is entered.
   function automatic void enter_step(input logic [STEP_W-1:0] nxt, input logic sda);
      step = nxt;
      case (nxt)
         S_ST_A: begin
            scl = 1'b1; sda_lvl = 1'b1; sda_en = 1'b1;
         end
         S_ST_B:  sda_lvl = 1'b0;
         S_TX_LO: begin
            scl = 1'b0; sda_lvl = shreg[7]; sda_en = 1'b1;
         end
         S_TX_HI: scl = 1'b1;
         S_ACK_LO: begin
            scl = 1'b0; sda_en = 1'b0;
         end
         S_ACK_HI: scl = 1'b1;
         S_ACK_END: begin
            if (!rd_mode && sda) err_flag = 1'b1;
            scl    = 1'b0;
            sda_en = 1'b1;
            if (!rd_mode && byte_no == BYTE_DATA) sda_lvl = 1'b0;
         end
         S_STOP_LO:  sda_lvl = 1'b0;
         S_STOP_HI:  scl = 1'b1;
         S_STOP_END: sda_lvl = 1'b1;
         S_RX_REL:   sda_en = 1'b0;
         S_RX_HI: begin
            scl   = 1'b1;
            shreg = {shreg[6:0], sda};
         end
         S_RX_LO: begin
            scl = 1'b0;
            if (bit_idx >= 4'd7) begin
               sda_en  = 1'b1;
               rx_byte = shreg;
            end
         end
         S_NA_HI: begin
            sda_lvl = 1'b1; scl = 1'b1;
         end
         S_NA_LO:  scl = 1'b0;
         S_NA_SDA: sda_lvl = 1'b0;
         default: ;
      endcase
   endfunction

   // Moves to the next event at the end of a unit; returns 1 when the transaction ends.
   function automatic logic advance_step(input logic sda);
      logic finished;
      finished = 1'b0;
      case (step)
         S_ST_A: enter_step(S_ST_B, sda);
         S_ST_B: begin
            bit_idx = '0;
            enter_step(S_TX_LO, sda);
         end
         S_TX_LO: enter_step(S_TX_HI, sda);
         S_TX_HI: begin
            if (bit_idx < 4'd7) begin
               bit_idx = bit_idx + 4'd1;
               shreg   = {shreg[6:0], 1'b0};
               enter_step(S_TX_LO, sda);
            end else begin
               enter_step(S_ACK_LO, sda);
            end
         end
         S_ACK_LO: enter_step(S_ACK_HI, sda);
         S_ACK_HI: enter_step(S_ACK_END, sda);
         S_ACK_END: begin
            // The data byte of a write goes straight to the stop, SDA already low.
            if (!rd_mode && byte_no == BYTE_DATA) enter_step(S_STOP_HI, sda);
            else enter_step(S_GAP, sda);
         end
         S_GAP: begin
            if (rd_mode && byte_no == BYTE_REG) begin
               enter_step(S_STOP_LO, sda);
            end else if (rd_mode && byte_no == BYTE_DATA) begin
               enter_step(S_RX_REL, sda);
            end else begin
               byte_no = byte_no + 2'd1;
               shreg   = (byte_no == BYTE_REG) ? held_reg : held_val;
               bit_idx = '0;
               enter_step(S_TX_LO, sda);
            end
         end
         S_STOP_LO: enter_step(S_STOP_HI, sda);
         S_STOP_HI: enter_step(S_STOP_END, sda);
         S_STOP_END: begin
            if (rd_mode && byte_no == BYTE_REG) begin
               enter_step(S_GAP_S1, sda);
            end else begin
               step     = S_IDLE;
               finished = 1'b1;
            end
         end
         S_GAP_S1: enter_step(S_GAP_S2, sda);
         S_GAP_S2: begin
            byte_no = BYTE_DATA;
            shreg   = dev_addr | 8'h01;
            enter_step(S_ST_A, sda);
         end
         S_RX_REL: begin
            bit_idx = '0;
            enter_step(S_RX_HI, sda);
         end
         S_RX_HI: enter_step(S_RX_LO, sda);
         S_RX_LO: begin
            if (bit_idx < 4'd7) begin
               bit_idx = bit_idx + 4'd1;
               enter_step(S_RX_HI, sda);
            end else begin
               enter_step(S_NA_HI, sda);
            end
         end
         S_NA_HI:  enter_step(S_NA_LO, sda);
         S_NA_LO:  enter_step(S_NA_SDA, sda);
         S_NA_SDA: enter_step(S_STOP_LO, sda);
         default:  step = S_IDLE;
      endcase
      return finished;
   endfunction

   function automatic line_state_type predict_tick(input logic [REQ_DATA_W-1:0] beat);
      logic [1:0]     cmd;
      logic           sda;
      int             limit;
      line_state_type levels;
      cmd   = beat[1:0];
      sda   = beat[18];
      limit = (unit_ticks == 16'd0) ? 1 : int'(unit_ticks);
      levels.done = 1'b0;
      if (step == S_IDLE) begin
         if (cmd == CMD_READ || cmd == CMD_WRITE) begin
            rd_mode  = (cmd == CMD_READ);
            held_reg = beat[9:2];
            held_val = beat[17:10];
            if (!rd_mode) err_flag = 1'b0;
            byte_no  = BYTE_ADDR;
            bit_idx  = '0;
            shreg    = dev_addr;
            unit_cnt = 0;
            enter_step(S_ST_A, sda);
         end
      end else begin
         unit_cnt = unit_cnt + 1;
         if (unit_cnt >= limit) begin
            unit_cnt    = 0;
            levels.done = advance_step(sda);
         end
      end
      levels.scl     = scl;
      levels.sda_lvl = sda_lvl;
      levels.sda_en  = sda_en;
      levels.busy    = (step != S_IDLE);
      levels.rx_byte = rx_byte;
      levels.err     = err_flag;
      return levels;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      line_state_type want;
      if (reset) begin
         clear_sequencer();
         levels_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEVICE_ADDRESS: dev_addr   = csr_data[7:0];
               CSR_TICKS_PER_UNIT: unit_ticks = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) levels_due.push_back(predict_tick(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (levels_due.size() == 0) begin
               mismatches++;
               if (mismatches <= PRINT_CAP)
                  $display("%0t: result beat with nothing expected, expected none, actual %h",
                           $time, rsp_tdata);
            end else begin
               want = levels_due.pop_front();
               check_field("scl_out", want.scl, rsp_tdata[0]);
               check_field("sda_drive", want.sda_lvl, rsp_tdata[1]);
               check_field("sda_enable", want.sda_en, rsp_tdata[2]);
               check_field("busy_res", want.busy, rsp_tdata[3]);
               check_field("done_res", want.done, rsp_tdata[4]);
               check_field("read_result", want.rx_byte, rsp_tdata[12:5]);
               check_field("ack_error", want.err, rsp_tdata[13]);
            end
         end
      end
      pending_beats <= levels_due.size();
      seq_active    <= (step != S_IDLE);
      fail_count    <= mismatches;
   end

endmodule

/* tb/sv/tb_sccb_register_master.sv */
// Testbench top for the SCCB register master: clock, reset, stimulus, pacing and verdict.
module tb_sccb_register_master;
   import sccb_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int RUN_LIMIT = 1000000;
   localparam int LONG_HOLD = 150;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = 1'b0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int          fail_count;
   int          pending_beats;
   logic        seq_active;
   bit          quiet = 1'b0;
   int          holds_asked = 0;
   int unsigned cycle_count = 0;

   sccb_register_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sccb_line_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_beats (pending_beats),
      .seq_active    (seq_active)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side pacing: random stall bursts, plus one long hold when asked for.
   initial begin
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done  = holds_asked;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [1:0] any_request();
      case ($urandom_range(0, 2))
         0:       return CMD_READ;
         1:       return CMD_WRITE;
         default: return CMD_SPARE;
      endcase
   endfunction

   // Offers one tick beat and returns at the edge where it is taken.
   task automatic send_tick(input logic [1:0] cmd, input logic [7:0] regv,
                            input logic [7:0] val, input logic sda);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, sda, val, regv, cmd};
      do @(posedge clock); while (!req_tready);
   endtask

   // Ticks the sequencer back to idle, then stops and waits for every result.
   task automatic settle_idle();
      do send_tick(CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      while (seq_active);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] addr_word,
                            input logic [CSR_DATA_W-1:0] ticks);
      write_csr(CSR_DEVICE_ADDRESS, addr_word);
      write_csr(CSR_TICKS_PER_UNIT, ticks);
      csr_valid <= 1'b0;
   endtask

   // One request, then ticks until the sequencer is idle. noise_pct of the ticks carry
   // a request too, which the block must ignore while busy. bias is the chance of SDA high.
   task automatic run_txn(input logic [1:0] cmd, input logic [7:0] regv, input logic [7:0] val,
                          input int bias, input int noise_pct);
      logic [1:0] c;
      send_tick(cmd, regv, val, 1'($urandom_range(0, 1)));
      do begin
         c = ($urandom_range(0, 99) < noise_pct) ? any_request() : CMD_TICK;
         send_tick(c, 8'($urandom), 8'($urandom), $urandom_range(0, 99) < bias);
      end while (seq_active);
   endtask

   task automatic run_stream(input int beats);
      int         bias;
      logic [1:0] c;
      bias = 0;
      repeat (beats) begin
         if ($urandom_range(0, 49) == 0) begin
            case ($urandom_range(0, 3))
               0:       bias = 100;
               1:       bias = 50;
               default: bias = 0;
            endcase
         end
         c = ($urandom_range(0, 99) < 15) ? any_request() : CMD_TICK;
         send_tick(c, 8'($urandom), 8'($urandom), $urandom_range(0, 99) < bias);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset configuration first.
      send_tick(CMD_TICK, 8'h00, 8'h00, 1'b0);
      send_tick(CMD_SPARE, 8'hFF, 8'hFF, 1'b1);
      send_tick(CMD_TICK, 8'hFF, 8'hFF, 1'b1);
      run_txn(CMD_WRITE, 8'h00, 8'hFF, 0, 0);
      run_txn(CMD_WRITE, 8'hFF, 8'h00, 100, 0);
      run_txn(CMD_READ, 8'hA5, 8'h5A, 50, 20);
      run_txn(CMD_WRITE, 8'h3C, 8'hC3, 0, 100);
      settle_idle();

      // Odd device address with junk above the byte, zero ticks per unit.
      configure({8'($urandom), 8'hFF}, 16'd0);
      run_txn(CMD_READ, 8'h00, 8'hFF, 50, 0);
      run_txn(CMD_WRITE, 8'h81, 8'h7E, 50, 10);
      settle_idle();

      configure(16'h0000, 16'd2);
      run_txn(CMD_WRITE, 8'($urandom), 8'($urandom), 0, 5);
      run_txn(CMD_READ, 8'($urandom), 8'($urandom), 50, 5);
      settle_idle();

      // Longest unit: idle ticks only, since a transaction would outlast the run limit.
      configure(16'd254, 16'hFFFF);
      repeat (20) send_tick(CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      settle_idle();

      // Random part.
      configure({8'h00, 8'($urandom)}, 16'd1);
      run_stream(30);
      holds_asked = holds_asked + 1;
      run_stream(60);
      settle_idle();

      configure({8'h00, 8'($urandom)}, 16'd2);
      run_stream(60);
      settle_idle();

      configure({8'h00, 8'($urandom)}, 16'($urandom_range(1, 4)));
      run_stream(40);
      settle_idle();

      quiet = 1'b1;
      configure({8'h00, 8'($urandom) & 8'hFE}, 16'd1);
      run_stream(40);
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending_beats != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
